>>> src/stmf_pkg.sv
// shared constants and types for the sine template matched filter
package stmf_pkg;

    // defaults for the top-level parameters
    localparam int MAX_TAPS_DEF        = 256;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // fixed field widths
    localparam int PHASE_W     = 32;
    localparam int TAP_COUNT_W = 9;
    localparam int RESULT_W    = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // sine template word, signed q1.15
    localparam int SINE_W     = 16;
    localparam int FRAC_SHIFT = 15;

    // magnitude kept for squaring, larger values always saturate the energy
    localparam int MAG_W = 23;
    localparam int SQ_W  = MAG_W + 1;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 9'd256;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_TAP_COUNT   = 2'd1,
        CFG_ENERGY_MODE = 2'd2
    } cfg_reg_t;

    // sequencer to arithmetic unit controls
    typedef struct packed {
        logic acc_clear;
        logic tap_mul;
        logic acc_add;
        logic mag_load;
        logic sq_mul;
    } mac_ctrl_t;

endpackage

>>> src/stmf_if.sv
// stream and configuration interfaces of the sine template matched filter

interface stmf_sample_if #(
    parameter int SAMPLE_BITS = stmf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface stmf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [stmf_pkg::RESULT_W-1:0] filter_value;

    modport source (output valid, output filter_value, input ready);
    modport sink   (input valid, input filter_value, output ready);
endinterface

interface stmf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [stmf_pkg::CFG_IDX_W-1:0]   index;
    logic [stmf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/sine_template_matched_filter_unit.sv
// sine template matched filter: sequencer, window memory and config registers
// flow: a sample runs SETUP, the MAC pass and DONE before result valid, with
//   MAG and SQUARE in energy mode (zero or oversize tap_count as 1 or MAX_TAPS)
// throughput: one sample per pass, as input is ready only in IDLE; the pace is
//   set by the single mac pass, one tap per cycle, and by results.ready
// reset: window reads as zero until written, head at zero, phase_step 0,
//   tap_count 256, energy_mode 0; no clearing pass, input is ready right away
module sine_template_matched_filter_unit #(
    parameter int MAX_TAPS        = stmf_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS     = stmf_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stmf_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    stmf_sample_if.sink   samples,
    stmf_result_if.source results,
    stmf_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int PW    = stmf_pkg::PHASE_W;

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETUP  = 6'b000010,
        S_MAC    = 6'b000100,
        S_MAG    = 6'b001000,
        S_SQUARE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic [PW-1:0]                    phase_step_reg;
    logic [stmf_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic                             energy_mode_reg;

    // window bookkeeping
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] fill_reg;

    // tap walk
    logic [IDX_W-1:0] pos_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] taps_reg;
    logic [PW-1:0]    phase_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             ent_v1_reg;

    // output holding register
    logic                                 out_valid_reg;
    logic signed [stmf_pkg::RESULT_W-1:0] out_value_reg;

    logic                                 in_accept;
    logic                                 out_free;
    logic                                 issue;
    logic                                 ent_ok;
    logic [31:0]                          tc_wide;
    logic [CNT_W-1:0]                     taps_eff;
    logic [IDX_W-1:0]                     head_inc;
    logic [IDX_W-1:0]                     pos_inc;
    logic [IDX_W+1:0]                     start_sum;
    logic [IDX_W-1:0]                     start_pos;
    logic [SAMPLE_BITS-1:0]               win_rdata;
    logic signed [stmf_pkg::SINE_W-1:0]   sine_val;
    logic signed [stmf_pkg::RESULT_W-1:0] mac_result;
    stmf_pkg::mac_ctrl_t                  ctrl;

    assign in_accept     = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || results.ready;
    assign issue         = (state_reg == S_MAC) && (k_reg != taps_reg);

    // entries at or past the fill count were never written and read as zero
    assign ent_ok = CNT_W'(pos_reg) < fill_reg;

    // effective tap count: zero acts as one, oversize clamps to the window
    always_comb
    begin
        tc_wide = 32'(tap_count_reg);
        if (tc_wide == 32'd0)
        begin
            taps_eff = CNT_W'(1);
        end
        else if (tc_wide > 32'(MAX_TAPS))
        begin
            taps_eff = CNT_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = CNT_W'(tc_wide);
        end
    end

    // circular index arithmetic, window need not be a power of two
    always_comb
    begin
        head_inc  = (head_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : head_reg + 1'b1;
        pos_inc   = (pos_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : pos_reg + 1'b1;
        // oldest sample of the window pairs with tap 0
        start_sum = (IDX_W+2)'(head_reg) + (IDX_W+2)'(MAX_TAPS) - (IDX_W+2)'(taps_eff);
        if (start_sum >= (IDX_W+2)'(MAX_TAPS))
        begin
            start_pos = IDX_W'(start_sum - (IDX_W+2)'(MAX_TAPS));
        end
        else
        begin
            start_pos = IDX_W'(start_sum);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                // leave once every tap is issued and the mac pipe is empty
                if ((k_reg == taps_reg) && !v1_reg && !v2_reg)
                begin
                    state_next = energy_mode_reg ? S_MAG : S_DONE;
                end
            end
            S_MAG:
            begin
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.acc_clear = (state_reg == S_SETUP);
        ctrl.tap_mul   = v1_reg;
        ctrl.acc_add   = v2_reg;
        ctrl.mag_load  = (state_reg == S_MAG);
        ctrl.sq_mul    = (state_reg == S_SQUARE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_step_reg  <= '0;
            tap_count_reg   <= stmf_pkg::TAP_COUNT_RESET;
            energy_mode_reg <= 1'b0;
            head_reg        <= '0;
            fill_reg        <= '0;
            pos_reg         <= '0;
            k_reg           <= '0;
            taps_reg        <= '0;
            phase_reg       <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // config transaction
            if (cfg.valid && cfg.ready)
            begin
                case (stmf_pkg::cfg_reg_t'(cfg.index))
                    stmf_pkg::CFG_PHASE_STEP:
                    begin
                        phase_step_reg <= cfg.data[PW-1:0];
                    end
                    stmf_pkg::CFG_TAP_COUNT:
                    begin
                        tap_count_reg <= cfg.data[stmf_pkg::TAP_COUNT_W-1:0];
                    end
                    stmf_pkg::CFG_ENERGY_MODE:
                    begin
                        energy_mode_reg <= cfg.data[0];
                    end
                    default:
                    begin
                        // unmapped index, write dropped
                    end
                endcase
            end

            // new sample goes to the head slot
            if (in_accept)
            begin
                head_reg <= head_inc;
                if (fill_reg != CNT_W'(MAX_TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            if (state_reg == S_SETUP)
            begin
                taps_reg  <= taps_eff;
                pos_reg   <= start_pos;
                k_reg     <= '0;
                phase_reg <= '0;
            end
            else if (issue)
            begin
                k_reg     <= k_reg + 1'b1;
                pos_reg   <= pos_inc;
                phase_reg <= phase_reg + phase_step_reg;
            end

            // read stage, then multiply stage
            v1_reg <= issue;
            v2_reg <= v1_reg;

            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_v1_reg <= ent_ok;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_value_reg <= mac_result;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.filter_value = out_value_reg;

    stmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_window (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (head_reg),
        .wr_data (samples.sample),
        .rd_en   (issue),
        .rd_addr (pos_reg),
        .rd_data (win_rdata)
    );

    stmf_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .clk   (clk),
        .en    (issue),
        .phase (phase_reg),
        .sine  (sine_val)
    );

    stmf_mac_unit #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk         (clk),
        .ctrl        (ctrl),
        .energy_mode (energy_mode_reg),
        .tap_valid   (ent_v1_reg),
        .tap_sample  ($signed(win_rdata)),
        .tap_sine    (sine_val),
        .result      (mac_result)
    );

    // an accepted sample always starts a pass
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_SETUP))
        else $error("accepted sample did not start a pass");

    // tap counter never runs past the tap count
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (k_reg <= taps_reg))
        else $error("tap counter overran");

    // fill count saturates at the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_TAPS))
        else $error("fill count beyond window");

    // products only reach the accumulator during the mac pass
    a_pipe_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> (state_reg == S_MAC))
        else $error("mac pipe busy outside the pass");

    // a finished pass always shows a result
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> out_valid_reg)
        else $error("result not loaded");

endmodule

>>> src/stmf_ram.sv
// generic single write port ram with registered read
module stmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/stmf_sine_rom.sv
// quarter-wave sine template lookup with registered output
module stmf_sine_rom #(
    parameter int SINE_TABLE_BITS = stmf_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [stmf_pkg::PHASE_W-1:0]        phase,
    output logic signed [stmf_pkg::SINE_W-1:0]  sine
);

    localparam int TB      = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (TB - 2);
    localparam int MAG_BITS = stmf_pkg::SINE_W - 1;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // (a * b) >> 62, truncated to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // restoring division, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(32767 * sin(pi/2 * i / quarter)) by taylor series in q62
    function automatic logic [MAG_BITS-1:0] quarter_sine(input int i);
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        frac = 64'(i) << (64 - TB);
        x    = mul_q62(HALF_PI_Q62, frac);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < 40; n++)
        begin
            term = div_u64(mul_q62(term, x2), 64'((2 * n) * (2 * n + 1)));
            if ((n & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        scaled = (((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
        return scaled[MAG_BITS-1:0];
    endfunction

    logic [MAG_BITS-1:0] qtab [QUARTER+1];

    genvar gi;
    generate
        for (gi = 0; gi <= QUARTER; gi++)
        begin : g_qtab
            localparam logic [MAG_BITS-1:0] QVAL = quarter_sine(gi);
            assign qtab[gi] = QVAL;
        end
    endgenerate

    logic [TB-1:0]                      idx;
    logic [TB-2:0]                      qi;
    logic signed [stmf_pkg::SINE_W-1:0] mag;
    logic signed [stmf_pkg::SINE_W-1:0] sine_reg;

    always_comb
    begin
        idx = phase[stmf_pkg::PHASE_W-1 -: TB];
        // odd quadrants run the quarter table backward
        if (idx[TB-2])
        begin
            qi = (TB-1)'(QUARTER) - (TB-1)'(idx[TB-3:0]);
        end
        else
        begin
            qi = (TB-1)'(idx[TB-3:0]);
        end
        mag = $signed(stmf_pkg::SINE_W'(qtab[qi]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= idx[TB-1] ? -mag : mag;
        end
    end

    assign sine = sine_reg;

endmodule

>>> src/stmf_mac_unit.sv
// shared multiplier, accumulator and result shaping
module stmf_mac_unit #(
    parameter int MAX_TAPS    = stmf_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = stmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  stmf_pkg::mac_ctrl_t                  ctrl,
    input  logic                                 energy_mode,
    input  logic                                 tap_valid,
    input  logic signed [SAMPLE_BITS-1:0]        tap_sample,
    input  logic signed [stmf_pkg::SINE_W-1:0]   tap_sine,
    output logic signed [stmf_pkg::RESULT_W-1:0] result
);

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int SUM_W  = SAMPLE_BITS + stmf_pkg::SINE_W + IDX_W + 1;
    localparam int MUL_W  = (SAMPLE_BITS > stmf_pkg::SQ_W) ? SAMPLE_BITS : stmf_pkg::SQ_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int VAL_W  = ACC_W - stmf_pkg::FRAC_SHIFT;
    localparam int RW     = stmf_pkg::RESULT_W;
    localparam int MW     = stmf_pkg::MAG_W;

    localparam logic [RW-1:0] POS_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] NEG_MAX = {1'b1, {(RW-1){1'b0}}};

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W:0]    value_x;
    logic [VAL_W:0]           abs_v;
    logic [MW-1:0]            mag_reg;
    logic                     mag_sat_reg;
    logic [VAL_W-RW:0]        value_hi;
    logic [RW-1:0]            plain_v;
    logic [RW-1:0]            energy_v;

    // operand select for the one multiplier
    always_comb
    begin
        if (ctrl.sq_mul)
        begin
            op_a = $signed(MUL_W'({1'b0, mag_reg}));
            op_b = $signed(MUL_W'({1'b0, mag_reg}));
        end
        else
        begin
            // entries never written since reset count as zero
            op_a = tap_valid ? MUL_W'(tap_sample) : '0;
            op_b = MUL_W'(tap_sine);
        end
    end

    // floor shift, then magnitude for the energy square
    always_comb
    begin
        value    = acc_reg[ACC_W-1:stmf_pkg::FRAC_SHIFT];
        value_x  = {value[VAL_W-1], value};
        abs_v    = value_x[VAL_W] ? -value_x : value_x;
        value_hi = value[VAL_W-1:RW-1];
        if ((&value_hi) || !(|value_hi))
        begin
            plain_v = value[RW-1:0];
        end
        else
        begin
            plain_v = value[VAL_W-1] ? NEG_MAX : POS_MAX;
        end
        energy_v = mag_sat_reg ? POS_MAX : prod_reg[stmf_pkg::FRAC_SHIFT +: RW];
        result   = $signed(energy_mode ? energy_v : plain_v);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tap_mul || ctrl.sq_mul)
        begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.mag_load)
        begin
            mag_reg     <= abs_v[MW-1:0];
            mag_sat_reg <= |abs_v[VAL_W:MW];
        end
    end

endmodule
